>>> rtl/core/smmp_pkg.sv
// Package for the symbolic mode mask parser: constants, parse state type, helper functions.
`default_nettype none
package smmp_pkg;

    localparam int unsigned MASK_W = 9;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned OCT_W  = 10;

    localparam logic [MASK_W-1:0] PERM_ALL    = 9'o777;
    localparam logic [MASK_W-1:0] CLS_U       = 9'o700;
    localparam logic [MASK_W-1:0] CLS_G       = 9'o070;
    localparam logic [MASK_W-1:0] CLS_O       = 9'o007;
    localparam logic [MASK_W-1:0] START_RESET = 9'o022;

    localparam logic [OCT_W-1:0] OCT_SAT = 10'd512;
    localparam logic [OCT_W-1:0] OCT_MAX = 10'o777;

    localparam logic [2:0] TRIP_R = 3'd4;
    localparam logic [2:0] TRIP_W = 3'd2;
    localparam logic [2:0] TRIP_X = 3'd1;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_SET = 2'd2
    } t_op;

    typedef struct packed {
        logic [MASK_W-1:0] work_mode;
        logic [MASK_W-1:0] who_set;
        logic              who_given;
        logic              in_perm_list;
        t_op               pending_op;
        logic [MASK_W-1:0] pending_bits;
        logic              symbolic_error;
        logic [OCT_W-1:0]  octal_value;
        logic              octal_valid;
        logic              octal_broken;
    } t_parse_state;

    function automatic t_parse_state clear_state(input logic [MASK_W-1:0] start_mask);
        t_parse_state s;
        s.work_mode      = ~start_mask;
        s.who_set        = '0;
        s.who_given      = 1'b0;
        s.in_perm_list   = 1'b0;
        s.pending_op     = OP_ADD;
        s.pending_bits   = '0;
        s.symbolic_error = 1'b0;
        s.octal_value    = '0;
        s.octal_valid    = 1'b0;
        s.octal_broken   = 1'b0;
        return s;
    endfunction

    function automatic logic [MASK_W-1:0] spread_triplet(input logic [2:0] trip,
                                                         input logic [MASK_W-1:0] targets);
        logic [MASK_W-1:0] r;
        r = '0;
        if ((targets & CLS_U) != '0) r = r | {trip, 6'b0};
        if ((targets & CLS_G) != '0) r = r | {3'b0, trip, 3'b0};
        if ((targets & CLS_O) != '0) r = r | {6'b0, trip};
        return r;
    endfunction

    function automatic logic [MASK_W-1:0] apply_pending(input t_parse_state s);
        logic [MASK_W-1:0] m;
        case (s.pending_op)
            OP_SET:  m = (s.work_mode & ~s.who_set) | (s.pending_bits & s.who_set);
            OP_SUB:  m = s.work_mode & ~s.pending_bits;
            default: m = s.work_mode | s.pending_bits;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/symbolic_mode_mask_parser.sv
// Top level of the symbolic mode mask parser: input register, parse state, result register.
// The block takes one character item per cycle and a closing end-marker item, and returns one
// result per end marker: the octal mask if the string is a valid octal value up to 0777,
// otherwise the mask from the symbolic clauses, or start_mask with parse_ok low on failure.
// Every item passes an input register and is then folded into the parse state; an end marker
// waits in the input register while the output is stalled, and its result goes to the result
// register when it is folded in. Sustained rate is one item per cycle; the input stalls only
// while a finished result is held by a stalled output and the next end marker waits behind it.
// Write start_mask only while the block is idle; the write also clears any partly parsed string.
`default_nettype none
module symbolic_mode_mask_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_is_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [8:0] o_new_mask,
    output logic       o_parse_ok
);
    import smmp_pkg::*;

    t_parse_state      r_state;
    t_parse_state      n_state;
    logic [MASK_W-1:0] r_start;
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_end;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_mask;
    logic              r_out_ok;
    logic [MASK_W-1:0] n_out_mask;
    logic              n_out_ok;
    logic              out_free;
    logic              s_go;
    logic              in_acc;

    smmp_step u_step (
        .i_state     (r_state),
        .i_char_code (r_in_char),
        .i_is_end    (r_in_end),
        .i_start_mask(r_start),
        .o_state     (n_state),
        .o_new_mask  (n_out_mask),
        .o_parse_ok  (n_out_ok)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s_go       = r_in_valid && (!r_in_end || out_free);
    assign o_in_stall = r_in_valid && !s_go;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (s_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_char <= i_char_code;
            r_in_end  <= i_is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
            r_state <= clear_state(START_RESET);
        end else if (i_cfg_we) begin
            r_start <= i_cfg_data;
            r_state <= clear_state(i_cfg_data);
        end else if (s_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_go && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && r_in_end) begin
            r_out_mask <= n_out_mask;
            r_out_ok   <= n_out_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_mask  = r_out_mask;
    assign o_parse_ok  = r_out_ok;

endmodule
`default_nettype wire

>>> rtl/core/smmp_step.sv
// Next-state and result logic for one character or end marker.
`default_nettype none
module smmp_step (
    input  smmp_pkg::t_parse_state    i_state,
    input  logic [7:0]                i_char_code,
    input  logic                      i_is_end,
    input  logic [8:0]                i_start_mask,
    output smmp_pkg::t_parse_state    o_state,
    output logic [8:0]                o_new_mask,
    output logic                      o_parse_ok
);
    import smmp_pkg::*;

    logic [12:0]       oct_next;
    logic              is_op;
    t_op               op;
    logic [MASK_W-1:0] applied;

    always_comb begin
        is_op = 1'b1;
        op    = OP_ADD;
        case (i_char_code)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_EQ:    op = OP_SET;
            default:  is_op = 1'b0;
        endcase
    end

    assign applied  = apply_pending(i_state);
    assign oct_next = {i_state.octal_value, 3'b000} + {10'b0, i_char_code[2:0]};

    always_comb begin
        o_state    = i_state;
        o_new_mask = i_start_mask;
        o_parse_ok = 1'b0;
        if (i_is_end) begin
            if (i_state.octal_valid && !i_state.octal_broken &&
                i_state.octal_value <= OCT_MAX) begin
                o_new_mask = i_state.octal_value[MASK_W-1:0];
                o_parse_ok = 1'b1;
            end else if (!i_state.symbolic_error && i_state.in_perm_list) begin
                o_new_mask = ~applied;
                o_parse_ok = 1'b1;
            end
            o_state = clear_state(i_start_mask);
        end else begin
            // octal path
            if (!i_state.octal_broken) begin
                if (i_char_code inside {[CH_0:CH_7]}) begin
                    o_state.octal_valid = 1'b1;
                    if (oct_next > {3'b0, OCT_SAT}) begin
                        o_state.octal_value = OCT_SAT;
                    end else begin
                        o_state.octal_value = oct_next[OCT_W-1:0];
                    end
                end else begin
                    o_state.octal_broken = 1'b1;
                end
            end
            // symbolic path
            if (!i_state.symbolic_error) begin
                if (!i_state.in_perm_list) begin
                    if (i_char_code inside {CH_U, CH_G, CH_O, CH_A}) begin
                        o_state.who_given = 1'b1;
                        case (i_char_code)
                            CH_U:    o_state.who_set = i_state.who_set | CLS_U;
                            CH_G:    o_state.who_set = i_state.who_set | CLS_G;
                            CH_O:    o_state.who_set = i_state.who_set | CLS_O;
                            default: o_state.who_set = PERM_ALL;
                        endcase
                    end else if (is_op) begin
                        if (!i_state.who_given) o_state.who_set = PERM_ALL;
                        o_state.in_perm_list = 1'b1;
                        o_state.pending_op   = op;
                        o_state.pending_bits = '0;
                    end else begin
                        o_state.symbolic_error = 1'b1;
                    end
                end else begin
                    case (i_char_code)
                        CH_R: o_state.pending_bits = i_state.pending_bits |
                                  spread_triplet(TRIP_R, i_state.who_set);
                        CH_W: o_state.pending_bits = i_state.pending_bits |
                                  spread_triplet(TRIP_W, i_state.who_set);
                        CH_X: o_state.pending_bits = i_state.pending_bits |
                                  spread_triplet(TRIP_X, i_state.who_set);
                        CH_U: o_state.pending_bits = i_state.pending_bits |
                                  spread_triplet(i_state.work_mode[8:6], i_state.who_set);
                        CH_G: o_state.pending_bits = i_state.pending_bits |
                                  spread_triplet(i_state.work_mode[5:3], i_state.who_set);
                        CH_O: o_state.pending_bits = i_state.pending_bits |
                                  spread_triplet(i_state.work_mode[2:0], i_state.who_set);
                        CH_PLUS, CH_MINUS, CH_EQ: begin
                            o_state.work_mode    = applied;
                            o_state.pending_op   = op;
                            o_state.pending_bits = '0;
                        end
                        CH_COMMA: begin
                            o_state.work_mode    = applied;
                            o_state.in_perm_list = 1'b0;
                            o_state.who_given    = 1'b0;
                            o_state.who_set      = '0;
                            o_state.pending_op   = OP_ADD;
                            o_state.pending_bits = '0;
                        end
                        default: o_state.symbolic_error = 1'b1;
                    endcase
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/smmp_checker.sv
// Port-level assertions for the symbolic mode mask parser, bound to the top level.
`default_nettype none
module smmp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [8:0] i_cfg_data,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_char_code,
    input logic       i_is_end,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [8:0] o_new_mask,
    input logic       o_parse_ok
);
    import smmp_pkg::*;

    logic [MASK_W-1:0] r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_data;
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_char_code) && $stable(i_is_end))
        else $error("input item changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_new_mask) && $stable(o_parse_ok))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_fail_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_parse_ok |-> o_new_mask == r_start)
        else $error("failed parse does not return start mask");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind symbolic_mode_mask_parser smmp_checker u_smmp_checker (.*);
`default_nettype wire
